/* hdl/bitplane_stego_extractor_unit_defines.svh */
// Assertion macros for the bit-plane extractor; empty when synthesising.
`ifndef BITPLANE_STEGO_EXTRACTOR_UNIT_DEFINES_SVH
`define BITPLANE_STEGO_EXTRACTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SEU_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bitplane extractor check failed");
`define SEU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitplane extractor check failed");
`else
`define SEU_ASSERT(label, prop)
`define SEU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/bse_pkg.sv */
// Shared types and constants of the bit-plane extractor.
package bse_pkg;

	localparam int POS_WIDTH_DEF = 24;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_W         = 25;
	localparam int SIZE_W        = 24;

	localparam logic [4:0] BITS_BYTE = 5'd8;
	localparam logic [4:0] BITS_SIZE = 5'd24;
	localparam logic [3:0] PLANE_SAT = 4'd8;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_FLAG = 3'd0,
		PH_NLEN = 3'd1,
		PH_SIZE = 3'd2,
		PH_NAME = 3'd3,
		PH_DATA = 3'd4,
		PH_IDLE = 3'd5
	} phase_t;

	// One classified request: the extracted bit, or a note that the planes ran out.
	typedef struct packed {
		logic plane_bit;
		logic over;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        value;
		logic [7:0]        name_length;
		logic [SIZE_W-1:0] payload_size;
		logic              last_record;
		logic              record_done;
		logic              all_done;
	} result_t;

endpackage

/* hdl/bse_front.sv */
// Front end: tracks position and plane, picks the plane bit of each byte.
module bse_front #(
	parameter int POS_WIDTH = bse_pkg::POS_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bse_pkg::CFG_W-1:0] image_bytes,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                cover_byte,
	output logic                      push,
	output bse_pkg::item_t            push_item
);

	localparam int CmpW = (POS_WIDTH + 1 > bse_pkg::CFG_W) ? POS_WIDTH + 1 : bse_pkg::CFG_W;

	logic [POS_WIDTH-1:0] position_q;
	logic [3:0]           plane_q;
	logic [POS_WIDTH:0]   next_pos;
	logic [CmpW-1:0]      next_ext;
	logic [CmpW-1:0]      limit_ext;
	logic                 wrap;

	assign push                = in_valid && in_ready;
	assign push_item.plane_bit = cover_byte[plane_q[2:0]];
	assign push_item.over      = plane_q[3];

	assign next_pos  = {1'b0, position_q} + {{POS_WIDTH{1'b0}}, 1'b1};
	assign next_ext  = CmpW'(next_pos);
	assign limit_ext = CmpW'(image_bytes);
	// a zero length wraps every byte, as a length of one would
	assign wrap      = (next_ext >= limit_ext) || next_pos[POS_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			plane_q    <= '0;
		end else if (push) begin
			if (wrap) begin
				position_q <= '0;
				if (plane_q != bse_pkg::PLANE_SAT) begin
					plane_q <= plane_q + 4'd1;
				end
			end else begin
				position_q <= next_pos[POS_WIDTH-1:0];
			end
		end
	end

endmodule

/* hdl/bse_queue.sv */
// Short queue of classified requests between front and back.
module bse_queue #(
	parameter int DEPTH = bse_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bse_pkg::item_t             push_item,
	output logic                       full,
	input  logic                       pop,
	output logic                       pop_valid,
	output bse_pkg::item_t             pop_item,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	bse_pkg::item_t mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CntW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem[rd_ptr_q];
	assign count     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* hdl/bse_back.sv */
// Back end: record parser and output register.
module bse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  bse_pkg::item_t  in_item,
	output logic            in_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output bse_pkg::result_t out_res
);

	localparam int SW = bse_pkg::SIZE_W;

	bse_pkg::phase_t phase_q, phase_n;
	logic            halted_q, halted_n;
	logic [4:0]      bit_count_q, bit_count_n;
	logic [SW-1:0]   shift_q, shift_n;
	logic [7:0]      name_len_q, name_len_n;
	logic [SW-1:0]   psize_q, psize_n;
	logic [SW-1:0]   bytes_left_q, bytes_left_n;
	logic            last_flag_q, last_flag_n;

	logic            take;
	logic [SW-1:0]   shifted;
	logic [4:0]      count_inc;
	logic [SW-1:0]   left_dec;

	logic             emit;
	bse_pkg::kind_t   emit_kind;
	logic [7:0]       emit_value;
	logic             emit_rdone;
	logic             emit_adone;

	logic             out_valid_q;
	bse_pkg::result_t res_q;

	assign take      = in_valid && (!out_valid_q || out_ready);
	assign in_pop    = take;
	assign shifted   = {in_item.plane_bit, shift_q[SW-1:1]};
	assign count_inc = bit_count_q + 5'd1;
	assign left_dec  = bytes_left_q - {{(SW-1){1'b0}}, 1'b1};

	// next state of the parser
	always_comb begin
		phase_n      = phase_q;
		halted_n     = halted_q;
		bit_count_n  = bit_count_q;
		shift_n      = shift_q;
		name_len_n   = name_len_q;
		psize_n      = psize_q;
		bytes_left_n = bytes_left_q;
		last_flag_n  = last_flag_q;
		if (take && !halted_q && phase_q != bse_pkg::PH_IDLE) begin
			if (in_item.over) begin
				halted_n = 1'b1;
			end else begin
				case (phase_q)
					bse_pkg::PH_FLAG: begin
						last_flag_n = in_item.plane_bit;
						bit_count_n = '0;
						shift_n     = '0;
						phase_n     = bse_pkg::PH_NLEN;
					end
					bse_pkg::PH_NLEN: begin
						shift_n     = shifted;
						bit_count_n = count_inc;
						if (count_inc == bse_pkg::BITS_BYTE) begin
							name_len_n  = shifted[SW-1:SW-8];
							shift_n     = '0;
							bit_count_n = '0;
							phase_n     = bse_pkg::PH_SIZE;
						end
					end
					bse_pkg::PH_SIZE: begin
						shift_n     = shifted;
						bit_count_n = count_inc;
						if (count_inc == bse_pkg::BITS_SIZE) begin
							psize_n     = shifted;
							shift_n     = '0;
							bit_count_n = '0;
							if (name_len_q != '0) begin
								phase_n      = bse_pkg::PH_NAME;
								bytes_left_n = SW'(name_len_q);
							end else if (shifted != '0) begin
								phase_n      = bse_pkg::PH_DATA;
								bytes_left_n = shifted;
							end else begin
								bytes_left_n = '0;
								phase_n = last_flag_q ? bse_pkg::PH_IDLE : bse_pkg::PH_FLAG;
							end
						end
					end
					bse_pkg::PH_NAME, bse_pkg::PH_DATA: begin
						shift_n     = shifted;
						bit_count_n = count_inc;
						if (count_inc == bse_pkg::BITS_BYTE) begin
							shift_n      = '0;
							bit_count_n  = '0;
							bytes_left_n = left_dec;
							if (left_dec != '0) begin
								phase_n = phase_q;
							end else if (phase_q == bse_pkg::PH_NAME && psize_q != '0) begin
								phase_n      = bse_pkg::PH_DATA;
								bytes_left_n = psize_q;
							end else begin
								phase_n = last_flag_q ? bse_pkg::PH_IDLE : bse_pkg::PH_FLAG;
							end
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	// result of the request taken this cycle
	always_comb begin
		emit       = 1'b0;
		emit_kind  = bse_pkg::KIND_HEADER;
		emit_value = '0;
		emit_rdone = 1'b0;
		emit_adone = 1'b0;
		if (take && !halted_q && phase_q != bse_pkg::PH_IDLE) begin
			if (in_item.over) begin
				emit      = 1'b1;
				emit_kind = bse_pkg::KIND_ERROR;
			end else begin
				case (phase_q)
					bse_pkg::PH_SIZE: begin
						if (count_inc == bse_pkg::BITS_SIZE) begin
							emit = 1'b1;
							if (name_len_q == '0 && shifted == '0) begin
								emit_rdone = 1'b1;
								emit_adone = last_flag_q;
							end
						end
					end
					bse_pkg::PH_NAME, bse_pkg::PH_DATA: begin
						if (count_inc == bse_pkg::BITS_BYTE) begin
							emit       = 1'b1;
							emit_kind  = (phase_q == bse_pkg::PH_NAME) ? bse_pkg::KIND_NAME
								: bse_pkg::KIND_DATA;
							emit_value = shifted[SW-1:SW-8];
							if (left_dec == '0 &&
								!(phase_q == bse_pkg::PH_NAME && psize_q != '0)) begin
								emit_rdone = 1'b1;
								emit_adone = last_flag_q;
							end
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= bse_pkg::PH_FLAG;
			halted_q     <= 1'b0;
			bit_count_q  <= '0;
			shift_q      <= '0;
			name_len_q   <= '0;
			psize_q      <= '0;
			bytes_left_q <= '0;
			last_flag_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			halted_q     <= halted_n;
			bit_count_q  <= bit_count_n;
			shift_q      <= shift_n;
			name_len_q   <= name_len_n;
			psize_q      <= psize_n;
			bytes_left_q <= bytes_left_n;
			last_flag_q  <= last_flag_n;
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken; load a new one only when emitting
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q.kind         <= emit_kind;
			res_q.value        <= emit_value;
			res_q.name_length  <= name_len_n;
			res_q.payload_size <= psize_n;
			res_q.last_record  <= last_flag_n;
			res_q.record_done  <= emit_rdone;
			res_q.all_done     <= emit_adone;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

/* hdl/bitplane_stego_extractor_unit.sv */
// Top level of the bit-plane extractor: config register, front, queue, back.
//
//   channel   dir   handshake                      carries
//   s_*       in    s_tvalid / s_tready            one cover byte per request
//   m_*       out   m_tvalid / m_tready            header, name, payload or error result
//   apb       in    psel, penable, pwrite, pready  image_bytes at address 0
//
// One byte is taken per cycle while the queue is not full; the front only steps
// position and plane and picks one bit, the back shifts it into the parsed field.
// A result is registered as its byte leaves the four-entry queue.
// A stalled output fills the queue, and s_tready drops once it is full.
// Reset returns the parser to the flag field, position and plane to zero.
`include "bitplane_stego_extractor_unit_defines.svh"
module bitplane_stego_extractor_unit #(
	parameter int POS_WIDTH = bse_pkg::POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] cover_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] value, [15:8] name_length,
	                               // [39:16] payload_size, [40] last_record, [41] all_done
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,   // record_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int QDepth = bse_pkg::QUEUE_DEPTH;
	localparam int CntW   = $clog2(QDepth + 1);

	logic [bse_pkg::CFG_W-1:0] image_bytes_q;
	logic                      push;
	bse_pkg::item_t            push_item;
	logic                      q_full;
	logic                      pop;
	logic                      pop_valid;
	bse_pkg::item_t            pop_item;
	logic [CntW-1:0]           q_count;
	bse_pkg::result_t          res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {7'b0, image_bytes_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_bytes_q <= 25'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			image_bytes_q <= pwdata[bse_pkg::CFG_W-1:0];
		end
	end

	assign s_tready = !q_full;

	bse_front #(
		.POS_WIDTH(POS_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image_bytes(image_bytes_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cover_byte (s_tdata),
		.push       (push),
		.push_item  (push_item)
	);

	bse_queue #(
		.DEPTH(QDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_item (pop_item),
		.count    (q_count)
	);

	bse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop_valid),
		.in_item  (pop_item),
		.in_pop   (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {6'b0, res.all_done, res.last_record, res.payload_size,
		res.name_length, res.value};
	assign m_tuser = res.kind;
	assign m_tlast = res.record_done;

	// input back-pressure comes only from a full queue
	`SEU_ASSERT(a_ready_tracks_queue, s_tready == (q_count != CntW'(QDepth)))
	// an error halts the parser: nothing follows it
	`SEU_ASSERT_NEXT(a_error_halts, m_tvalid && m_tready && m_tuser == bse_pkg::KIND_ERROR, !m_tvalid)
	`SEU_ASSERT(a_all_done_ends_record, !(m_tvalid && res.all_done) || m_tlast)

endmodule
